@@ rtl/kvlp_pkg.sv @@
// shared types and character constants for the key/value line parser
package kvlp_pkg;

  typedef enum logic [2:0] {
    KIND_NONE  = 3'd0,
    KIND_NAME  = 3'd1,
    KIND_VALUE = 3'd2,
    KIND_ENTRY = 3'd3,
    KIND_ERROR = 3'd4,
    KIND_DONE  = 3'd5
  } kind_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_file;
  } in_word_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] out_char;
    logic [4:0] name_length;
    logic [8:0] value_length;
  } out_word_t;

  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CASE_OFS = 8'h20;

endpackage

@@ rtl/key_value_line_parser_top.sv @@
// key/value line parser: one text byte or end-of-file mark in, one result word out
//
// Parses NAME=VALUE text lines at one input word per clock while in_stall_o
// is low. Every accepted word gives exactly one result word. The parse step
// is a small state update done in the accept cycle; the result lands in an
// output register backed by a one-entry skid register, so in_stall_o is a
// registered signal and only rises once the output register and the skid
// entry are both full. Throughput is one word per cycle while the output
// side takes words.
module key_value_line_parser_top
  import kvlp_pkg::*;
#(
  parameter int NAME_MAX  = 16,
  parameter int VALUE_MAX = 256
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  localparam int NW = $clog2(NAME_MAX + 1);
  localparam int VW = $clog2(VALUE_MAX + 1);

  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_NAME    = 3'd1;
  localparam logic [2:0] PH_PRESEP  = 3'd2;
  localparam logic [2:0] PH_POSTSEP = 3'd3;
  localparam logic [2:0] PH_VALUE   = 3'd4;
  localparam logic [2:0] PH_COMMENT = 3'd5;
  localparam logic [2:0] PH_ERROR   = 3'd6;

  function automatic logic is_name_char(input logic [7:0] c);
    is_name_char = (c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]})
                   || (c == CH_UNDER);
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    is_blank = (c == CH_SPACE) || (c == CH_TAB);
  endfunction

  function automatic logic is_eol(input logic [7:0] c);
    is_eol = (c == CH_LF) || (c == CH_CR);
  endfunction

  function automatic logic is_trim_space(input logic [7:0] c);
    is_trim_space = (c inside {CH_SPACE, CH_TAB, CH_VT, CH_FF});
  endfunction

  function automatic logic [7:0] upcase(input logic [7:0] c);
    upcase = (c inside {[8'h61:8'h7A]}) ? (c - CASE_OFS) : c;
  endfunction

  logic [2:0]    phase_q, phase_d;
  logic [NW-1:0] name_cnt_q, name_cnt_d;
  logic [VW-1:0] val_cnt_q, val_cnt_d;
  logic [VW-1:0] trim_cnt_q, trim_cnt_d;

  logic      out_valid_q, skid_valid_q;
  out_word_t out_word_q, skid_word_q;
  out_word_t res;
  logic      in_acc, out_acc;
  logic [7:0] c;

  assign in_acc  = in_valid_i && !skid_valid_q;
  assign out_acc = out_valid_q && !out_stall_i;
  assign c       = in_word_i.in_byte;

  // one parse step
  always_comb begin
    phase_d          = phase_q;
    name_cnt_d       = name_cnt_q;
    val_cnt_d        = val_cnt_q;
    trim_cnt_d       = trim_cnt_q;
    res.kind         = KIND_NONE;
    res.out_char     = 8'd0;
    res.name_length  = 5'd0;
    res.value_length = 9'd0;
    if (in_word_i.end_of_file) begin
      case (phase_q)
        PH_POSTSEP, PH_VALUE: begin
          res.kind         = KIND_ENTRY;
          res.name_length  = 5'(name_cnt_q);
          res.value_length = 9'(trim_cnt_q);
        end
        PH_NAME, PH_PRESEP: res.kind = KIND_ERROR;
        default:            res.kind = KIND_DONE;
      endcase
      phase_d    = PH_IDLE;
      name_cnt_d = '0;
      val_cnt_d  = '0;
      trim_cnt_d = '0;
    end else begin
      case (phase_q)
        PH_IDLE: begin
          if (c == CH_SEMI) begin
            phase_d = PH_COMMENT;
          end else if (is_blank(c) || is_eol(c)) begin
            phase_d = PH_IDLE;
          end else if (is_name_char(c)) begin
            name_cnt_d   = NW'(1);
            val_cnt_d    = '0;
            trim_cnt_d   = '0;
            phase_d      = PH_NAME;
            res.kind     = KIND_NAME;
            res.out_char = upcase(c);
          end else begin
            phase_d  = PH_ERROR;
            res.kind = KIND_ERROR;
          end
        end
        PH_NAME: begin
          if (is_blank(c)) begin
            phase_d = PH_PRESEP;
          end else if (c == CH_EQ) begin
            phase_d = PH_POSTSEP;
          end else if (is_name_char(c)) begin
            // characters past the cap are swallowed
            if (name_cnt_q < NW'(NAME_MAX)) begin
              name_cnt_d   = name_cnt_q + NW'(1);
              res.kind     = KIND_NAME;
              res.out_char = upcase(c);
            end
          end else begin
            phase_d  = PH_ERROR;
            res.kind = KIND_ERROR;
          end
        end
        PH_PRESEP: begin
          if (c == CH_EQ) begin
            phase_d = PH_POSTSEP;
          end else if (!is_blank(c)) begin
            phase_d  = PH_ERROR;
            res.kind = KIND_ERROR;
          end
        end
        PH_POSTSEP, PH_VALUE: begin
          if (is_eol(c)) begin
            res.kind         = KIND_ENTRY;
            res.name_length  = 5'(name_cnt_q);
            res.value_length = 9'(trim_cnt_q);
            phase_d          = PH_IDLE;
          end else if (!(phase_q == PH_POSTSEP && is_blank(c))) begin
            phase_d = PH_VALUE;
            if (val_cnt_q < VW'(VALUE_MAX)) begin
              val_cnt_d = val_cnt_q + VW'(1);
              // trimmed length follows the last non-space byte
              if (!is_trim_space(c)) begin
                trim_cnt_d = val_cnt_q + VW'(1);
              end
              res.kind     = KIND_VALUE;
              res.out_char = c;
            end
          end
        end
        PH_COMMENT: begin
          if (is_eol(c)) begin
            phase_d = PH_IDLE;
          end
        end
        default: phase_d = PH_ERROR;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      name_cnt_q <= '0;
      val_cnt_q  <= '0;
      trim_cnt_q <= '0;
    end else if (in_acc) begin
      phase_q    <= phase_d;
      name_cnt_q <= name_cnt_d;
      val_cnt_q  <= val_cnt_d;
      trim_cnt_q <= trim_cnt_d;
    end
  end

  // output register with one skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (skid_valid_q) begin
        if (out_acc) begin
          out_valid_q  <= 1'b1;
          skid_valid_q <= 1'b0;
        end
      end else if (in_acc) begin
        if (out_valid_q && out_stall_i) begin
          skid_valid_q <= 1'b1;
        end else begin
          out_valid_q <= 1'b1;
        end
      end else if (out_acc) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_acc) begin
        out_word_q <= skid_word_q;
      end
    end else if (in_acc) begin
      if (out_valid_q && out_stall_i) begin
        skid_word_q <= res;
      end else begin
        out_word_q <= res;
      end
    end
  end

  assign in_stall_o  = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held while output register empty");

  a_eof_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_word_i.end_of_file) |=> (phase_q == PH_IDLE))
    else $error("parser not idle after end of file");

  a_char_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.kind != KIND_NAME && out_word_o.kind != KIND_VALUE)
    |-> (out_word_o.out_char == 8'd0))
    else $error("character set on a non-character word");

  a_len_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.kind != KIND_ENTRY)
    |-> (out_word_o.name_length == 5'd0 && out_word_o.value_length == 9'd0))
    else $error("lengths set on a non-entry word");

  a_trim_le_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    trim_cnt_q <= val_cnt_q)
    else $error("trimmed value length exceeds stored count");

endmodule

@@ tb/kvlp_result_checker.sv @@
// checker for the key/value line parser: predicts every result word and compares it
module kvlp_result_checker
  import kvlp_pkg::*;
#(
  parameter int NAME_MAX  = 16,
  parameter int VALUE_MAX = 256
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_stall_i,
  input  in_word_t  in_word_i,
  input  logic      out_valid_i,
  input  logic      out_stall_i,
  input  out_word_t out_word_i,
  output int        mismatch_count_o,
  output int        pending_o
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_NAME,
    PH_PRE_EQ,
    PH_POST_EQ,
    PH_VALUE,
    PH_COMMENT,
    PH_ERROR
  } line_phase_e;

  line_phase_e line_phase;
  int          name_len;
  int          value_len;
  int          trimmed_len;
  out_word_t   expected_results_q[$];

  function automatic bit is_name_char(logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
           (c >= "a" && c <= "z") || c == CH_UNDER;
  endfunction

  function automatic bit is_blank(logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB;
  endfunction

  function automatic bit is_eol(logic [7:0] c);
    return c == CH_LF || c == CH_CR;
  endfunction

  function automatic logic [7:0] upper(logic [7:0] c);
    return (c >= "a" && c <= "z") ? c - CASE_OFS : c;
  endfunction

  function automatic void clear_line();
    line_phase  = PH_IDLE;
    name_len    = 0;
    value_len   = 0;
    trimmed_len = 0;
  endfunction

  // advances the parse state by one word and returns the result word it gives
  function automatic out_word_t parse_result(in_word_t w);
    out_word_t  r;
    logic [7:0] c;
    r = '0;
    r.kind = KIND_NONE;
    c = w.in_byte;
    if (w.end_of_file) begin
      case (line_phase)
        PH_POST_EQ, PH_VALUE: begin
          r.kind         = KIND_ENTRY;
          r.name_length  = name_len[4:0];
          r.value_length = trimmed_len[8:0];
        end
        PH_NAME, PH_PRE_EQ: r.kind = KIND_ERROR;
        default: r.kind = KIND_DONE;
      endcase
      clear_line();
    end else begin
      case (line_phase)
        PH_IDLE: begin
          if (c == CH_SEMI) begin
            line_phase = PH_COMMENT;
          end else if (is_blank(c) || is_eol(c)) begin
            // skipped while idle, also the LF of a CR LF pair
          end else if (is_name_char(c)) begin
            name_len    = 1;
            value_len   = 0;
            trimmed_len = 0;
            line_phase  = PH_NAME;
            r.kind      = KIND_NAME;
            r.out_char  = upper(c);
          end else begin
            line_phase = PH_ERROR;
            r.kind     = KIND_ERROR;
          end
        end
        PH_NAME: begin
          if (is_blank(c)) begin
            line_phase = PH_PRE_EQ;
          end else if (c == CH_EQ) begin
            line_phase = PH_POST_EQ;
          end else if (is_name_char(c)) begin
            // characters past the cap are swallowed
            if (name_len < NAME_MAX) begin
              name_len++;
              r.kind     = KIND_NAME;
              r.out_char = upper(c);
            end
          end else begin
            line_phase = PH_ERROR;
            r.kind     = KIND_ERROR;
          end
        end
        PH_PRE_EQ: begin
          if (c == CH_EQ) begin
            line_phase = PH_POST_EQ;
          end else if (!is_blank(c)) begin
            line_phase = PH_ERROR;
            r.kind     = KIND_ERROR;
          end
        end
        PH_POST_EQ, PH_VALUE: begin
          if (is_eol(c)) begin
            r.kind         = KIND_ENTRY;
            r.name_length  = name_len[4:0];
            r.value_length = trimmed_len[8:0];
            line_phase     = PH_IDLE;
          end else if (!(line_phase == PH_POST_EQ && is_blank(c))) begin
            line_phase = PH_VALUE;
            if (value_len < VALUE_MAX) begin
              value_len++;
              if (!(is_blank(c) || c == CH_VT || c == CH_FF)) trimmed_len = value_len;
              r.kind     = KIND_VALUE;
              r.out_char = c;
            end
          end
        end
        PH_COMMENT: begin
          if (is_eol(c)) line_phase = PH_IDLE;
        end
        default: line_phase = PH_ERROR;
      endcase
    end
    return r;
  endfunction

  task automatic check_field(string field, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatch_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t want;
    if (!rst_ni) begin
      clear_line();
      expected_results_q.delete();
      mismatch_count_o = 0;
      pending_o <= 0;
    end else begin
      // a word cannot leave in the cycle it came in, so pop before push
      if (out_valid_i && !out_stall_i) begin
        if (expected_results_q.size() == 0) begin
          $error("result word with none expected, kind %0d", out_word_i.kind);
          mismatch_count_o++;
        end else begin
          want = expected_results_q.pop_front();
          check_field("kind", want.kind, out_word_i.kind);
          check_field("out_char", want.out_char, out_word_i.out_char);
          check_field("name_length", want.name_length, out_word_i.name_length);
          check_field("value_length", want.value_length, out_word_i.value_length);
        end
      end
      if (in_valid_i && !in_stall_i) expected_results_q.push_back(parse_result(in_word_i));
      pending_o <= expected_results_q.size();
    end
  end

endmodule

@@ tb/tb_key_value_line_parser_top.sv @@
// testbench top for the key/value line parser: text stimulus, idling and verdict
module tb_key_value_line_parser_top;
  import kvlp_pkg::*;

  localparam int NAME_MAX     = 16;
  localparam int VALUE_MAX    = 256;
  localparam int WORD_TARGET  = 1950;
  localparam int LIMIT_CYCLES = 400000;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_word;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;
  int        mismatches;
  int        pending;

  int        send_idle_pct  = 0;
  int        recv_stall_pct = 0;
  int        words_sent     = 0;
  int        cycle_count    = 0;
  in_word_t  line_q[$];

  key_value_line_parser_top #(
    .NAME_MAX (NAME_MAX),
    .VALUE_MAX(VALUE_MAX)
  ) i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_word_i  (in_word),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_word_o (out_word)
  );

  kvlp_result_checker #(
    .NAME_MAX (NAME_MAX),
    .VALUE_MAX(VALUE_MAX)
  ) i_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .in_word_i       (in_word),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .out_word_i      (out_word),
    .mismatch_count_o(mismatches),
    .pending_o       (pending)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("key_value_line_parser_top: mismatch");
      $finish;
    end
  end

  function automatic void push_byte(logic [7:0] c);
    in_word_t w;
    w.in_byte     = c;
    w.end_of_file = 1'b0;
    line_q.push_back(w);
  endfunction

  // the byte beside an end-of-file mark is don't-care, so randomize it
  function automatic void push_eof();
    in_word_t w;
    w.in_byte     = 8'($urandom_range(255));
    w.end_of_file = 1'b1;
    line_q.push_back(w);
  endfunction

  function automatic void push_text(string s);
    foreach (s[i]) push_byte(s[i]);
  endfunction

  function automatic void push_blanks(int max_count);
    repeat ($urandom_range(max_count)) push_byte($urandom_range(1) ? CH_SPACE : CH_TAB);
  endfunction

  function automatic logic [7:0] name_char();
    logic [7:0] idx;
    idx = 8'($urandom_range(62));
    if (idx < 10) return "0" + idx;
    if (idx < 36) return "A" + idx - 8'd10;
    if (idx < 62) return "a" + idx - 8'd36;
    return CH_UNDER;
  endfunction

  // any byte but a line end, with blanks and vertical spacing made common
  function automatic logic [7:0] value_byte();
    logic [7:0] c;
    if ($urandom_range(3) == 0) begin
      case ($urandom_range(3))
        0: return CH_SPACE;
        1: return CH_TAB;
        2: return CH_VT;
        default: return CH_FF;
      endcase
    end
    do c = 8'($urandom_range(255)); while (c == CH_LF || c == CH_CR);
    return c;
  endfunction

  function automatic logic [7:0] CR_OR_LF();
    return $urandom_range(1) ? CH_CR : CH_LF;
  endfunction

  function automatic void push_line_end();
    case ($urandom_range(9))
      0, 1, 2, 3, 4: push_byte(CH_LF);
      5, 6: push_byte(CH_CR);
      7, 8: begin
        push_byte(CH_CR);
        push_byte(CH_LF);
      end
      default: push_eof();
    endcase
  endfunction

  function automatic void push_entry_line();
    int name_chars;
    int value_chars;
    name_chars  = ($urandom_range(9) == 0) ? $urandom_range(NAME_MAX - 1, NAME_MAX + 4)
                                           : $urandom_range(1, 6);
    value_chars = ($urandom_range(79) == 0) ? $urandom_range(VALUE_MAX - 6, VALUE_MAX + 6)
                                            : $urandom_range(0, 10);
    push_blanks(2);
    repeat (name_chars) push_byte(name_char());
    push_blanks(2);
    push_byte(CH_EQ);
    push_blanks(2);
    repeat (value_chars) push_byte(value_byte());
    push_line_end();
  endfunction

  function automatic void push_random_line();
    int pick;
    int pos;
    pick = $urandom_range(99);
    if (pick < 60) begin
      push_entry_line();
    end else if (pick < 70) begin
      push_blanks(1);
      push_byte(CH_SEMI);
      repeat ($urandom_range(8)) push_byte(value_byte());
      push_line_end();
    end else if (pick < 75) begin
      push_blanks(3);
      push_byte($urandom_range(1) ? CH_LF : CR_OR_LF());
    end else if (pick < 90) begin
      // broken entry: one byte replaced or the line cut short, then end of file
      push_entry_line();
      pos = $urandom_range(line_q.size() - 1);
      if ($urandom_range(1)) begin
        line_q[pos].in_byte = 8'($urandom_range(255));
      end else begin
        while (line_q.size() > pos) void'(line_q.pop_back());
      end
      push_eof();
    end else begin
      repeat ($urandom_range(1, 6)) push_byte(8'($urandom_range(255)));
      push_eof();
    end
  endfunction

  task automatic send_word(in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
    words_sent++;
  endtask

  task automatic send_line();
    while (line_q.size() > 0) send_word(line_q.pop_front());
  endtask

  initial begin
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_word  <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // lower case, digit and underscore in the name; nul, 0xff and trailing trim in the value
    push_text("a_9=");
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(CH_SPACE);
    push_byte(CH_VT);
    push_byte(CH_FF);
    push_byte(CH_CR);
    push_byte(CH_LF);
    // end of file inside a comment
    push_text(";c");
    push_eof();
    // bad byte at line start, then ignored bytes until end of file
    push_text("!x");
    push_eof();
    // end of file right after the equals sign
    push_byte(CH_TAB);
    push_text("Bb =");
    push_eof();
    // end of file inside a name, then at line start
    push_text("Z");
    push_eof();
    push_eof();
    send_line();

    while (words_sent < WORD_TARGET) begin
      case (words_sent * 4 / WORD_TARGET)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 81;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 81;
        end
        default: begin
          send_idle_pct  = 15;
          recv_stall_pct = 15;
        end
      endcase
      push_random_line();
      send_line();
    end
    in_valid <= 1'b0;

    // the checker's pending count is registered
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("key_value_line_parser_top: match");
    end else begin
      $display("key_value_line_parser_top: mismatch");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/kvlp_pkg.sv
rtl/key_value_line_parser_top.sv
tb/kvlp_result_checker.sv
tb/tb_key_value_line_parser_top.sv
